// ----- rtl/core/assert_macros.svh -----
// assertion macros shared by the rtl core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// expression must hold at every clock edge out of reset
`define ASSERT_ALWAYS(name, clk, rst, expr) \
   name: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("invariant check failed");

// consequent must hold in the same cycle as the antecedent
`define ASSERT_IMPL(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`else

`define ASSERT_ALWAYS(name, clk, rst, expr)
`define ASSERT_IMPL(name, clk, rst, ante, cons)
`define ASSERT_NEXT(name, clk, rst, ante, cons)

`endif

`endif

// ----- rtl/core/tcff_pkg.sv -----
package tcff_pkg;

   localparam int VALUE_WIDTH_DEF  = 32;
   localparam int SYMBOL_WIDTH_DEF = 16;

   localparam int KIND_W = 3;
   localparam int OP_W   = 4;
   localparam int OPK_W  = 2;

   // instruction kinds
   localparam logic [KIND_W-1:0] KIND_LABEL  = 3'd0;
   localparam logic [KIND_W-1:0] KIND_BINOP  = 3'd1;
   localparam logic [KIND_W-1:0] KIND_JZ     = 3'd2;
   localparam logic [KIND_W-1:0] KIND_GOTO   = 3'd3;
   localparam logic [KIND_W-1:0] KIND_ASSIGN = 3'd4;
   localparam logic [KIND_W-1:0] KIND_OTHER  = 3'd5;

   // operators
   localparam logic [OP_W-1:0] OP_ADD     = 4'd0;
   localparam logic [OP_W-1:0] OP_SUB     = 4'd1;
   localparam logic [OP_W-1:0] OP_MUL     = 4'd2;
   localparam logic [OP_W-1:0] OP_DIV     = 4'd3;
   localparam logic [OP_W-1:0] OP_EQ      = 4'd4;
   localparam logic [OP_W-1:0] OP_NE      = 4'd5;
   localparam logic [OP_W-1:0] OP_LT      = 4'd6;
   localparam logic [OP_W-1:0] OP_GT      = 4'd7;
   localparam logic [OP_W-1:0] OP_LE      = 4'd8;
   localparam logic [OP_W-1:0] OP_GE      = 4'd9;
   localparam logic [OP_W-1:0] OP_UNKNOWN = 4'd10;
   localparam logic [OP_W-1:0] OP_NONE    = 4'd11;

   // operand kinds
   localparam logic [OPK_W-1:0] OPND_EMPTY = 2'd0;
   localparam logic [OPK_W-1:0] OPND_LIT   = 2'd1;
   localparam logic [OPK_W-1:0] OPND_SYM   = 2'd2;
   localparam logic [OPK_W-1:0] OPND_BAD   = 2'd3;

   typedef struct packed {
      logic load;
      logic start;
      logic out_load;
   } tcff_cmd_type;

   typedef struct packed {
      logic is_label;
      logic needs_unit;
      logic emit;
      logic result_goto;
      logic unit_busy;
      logic unit_done;
   } tcff_status_type;

endpackage

// ----- rtl/core/tcff_seq_unit.sv -----
`include "assert_macros.svh"

// shared shift-add multiplier and restoring divider, one bit a cycle
module tcff_seq_unit
   import tcff_pkg::*;
#(
   parameter int WIDTH = VALUE_WIDTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic             is_div,
   input  logic [WIDTH-1:0] opnd_a,
   input  logic [WIDTH-1:0] opnd_b,
   output logic             busy,
   output logic             done,
   output logic [WIDTH-1:0] result
);

   localparam int CNT_W = $clog2(WIDTH);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WIDTH - 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [WIDTH-1:0] acc_ff, acc_in;
   logic [WIDTH-1:0] opa_ff, opa_in;
   logic [WIDTH-1:0] opb_ff, opb_in;
   logic             neg_ff, neg_in;
   logic             div_ff, div_in;

   logic [WIDTH-1:0] mag_a, mag_b;
   logic [WIDTH:0]   shifted, diff;
   logic             fits;

   assign mag_a   = opnd_a[WIDTH-1] ? (~opnd_a + 1'b1) : opnd_a;
   assign mag_b   = opnd_b[WIDTH-1] ? (~opnd_b + 1'b1) : opnd_b;
   assign shifted = {acc_ff, opa_ff[WIDTH-1]};
   assign diff    = shifted - {1'b0, opb_ff};
   assign fits    = ~diff[WIDTH];

   always_comb begin
      busy_in  = busy_ff;
      done_in  = done_ff;
      count_in = count_ff;
      acc_in   = acc_ff;
      opa_in   = opa_ff;
      opb_in   = opb_ff;
      neg_in   = neg_ff;
      div_in   = div_ff;
      if (start) begin
         busy_in  = 1'b1;
         done_in  = 1'b0;
         count_in = '0;
         acc_in   = '0;
         div_in   = is_div;
         neg_in   = opnd_a[WIDTH-1] ^ opnd_b[WIDTH-1];
         opa_in   = is_div ? mag_a : opnd_a;
         opb_in   = is_div ? mag_b : opnd_b;
      end else if (busy_ff) begin
         if (div_ff) begin
            acc_in = fits ? diff[WIDTH-1:0] : shifted[WIDTH-1:0];
            opa_in = {opa_ff[WIDTH-2:0], fits};
         end else begin
            acc_in = opb_ff[0] ? (acc_ff + opa_ff) : acc_ff;
            opa_in = {opa_ff[WIDTH-2:0], 1'b0};
            opb_in = {1'b0, opb_ff[WIDTH-1:1]};
         end
         count_in = count_ff + 1'b1;
         if (count_ff == CNT_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      opa_ff <= opa_in;
      opb_ff <= opb_in;
      neg_ff <= neg_in;
      div_ff <= div_in;
   end

   assign busy   = busy_ff;
   assign done   = done_ff;
   assign result = div_ff ? (neg_ff ? (~opa_ff + 1'b1) : opa_ff) : acc_ff;

   `ASSERT_ALWAYS(a_done_not_busy, clock, reset, !(done_ff && busy_ff))
   `ASSERT_NEXT(a_start_busy, clock, reset, start, busy_ff && !done_ff)

endmodule

// ----- rtl/core/tcff_datapath.sv -----
module tcff_datapath
   import tcff_pkg::*;
#(
   parameter int VALUE_WIDTH  = VALUE_WIDTH_DEF,
   parameter int SYMBOL_WIDTH = SYMBOL_WIDTH_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  tcff_cmd_type            cmd,
   output tcff_status_type         status,
   input  logic [KIND_W-1:0]       in_kind,
   input  logic [OP_W-1:0]         in_alu_op,
   input  logic [OPK_W-1:0]        in_first_kind,
   input  logic [VALUE_WIDTH-1:0]  in_first_value,
   input  logic [SYMBOL_WIDTH-1:0] in_first_symbol,
   input  logic [OPK_W-1:0]        in_second_kind,
   input  logic [VALUE_WIDTH-1:0]  in_second_value,
   input  logic [SYMBOL_WIDTH-1:0] in_second_symbol,
   input  logic [SYMBOL_WIDTH-1:0] in_dest_symbol,
   output logic [KIND_W-1:0]       out_kind,
   output logic [OP_W-1:0]         out_alu_op,
   output logic [OPK_W-1:0]        out_first_kind,
   output logic [VALUE_WIDTH-1:0]  out_first_value,
   output logic [SYMBOL_WIDTH-1:0] out_first_symbol,
   output logic [OPK_W-1:0]        out_second_kind,
   output logic [VALUE_WIDTH-1:0]  out_second_value,
   output logic [SYMBOL_WIDTH-1:0] out_second_symbol,
   output logic [SYMBOL_WIDTH-1:0] out_dest_symbol
);

   // working item
   logic [KIND_W-1:0]              kind_ff;
   logic [OP_W-1:0]                op_ff;
   logic [OPK_W-1:0]               k1_ff, k2_ff;
   logic signed [VALUE_WIDTH-1:0]  v1_ff, v2_ff;
   logic [SYMBOL_WIDTH-1:0]        s1_ff, s2_ff, dest_ff;

   // result register
   logic [KIND_W-1:0]       rkind_ff, rkind_in;
   logic [OP_W-1:0]         rop_ff, rop_in;
   logic [OPK_W-1:0]        rk1_ff, rk1_in, rk2_ff, rk2_in;
   logic [VALUE_WIDTH-1:0]  rv1_ff, rv1_in, rv2_ff, rv2_in;
   logic [SYMBOL_WIDTH-1:0] rs1_ff, rs1_in, rs2_ff, rs2_in, rdest_ff;

   logic                   lit_pair, fold_ok, use_unit, fold;
   logic [VALUE_WIDTH-1:0] quick_val, fold_val, unit_res;
   logic                   unit_busy, unit_done;
   logic                   jz_lit;
   logic [KIND_W-1:0]      f_kind;
   logic [OPK_W-1:0]       f_k1;
   logic [VALUE_WIDTH-1:0] f_v1;

   // normalised capture of the incoming transfer
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff <= (in_kind > KIND_OTHER) ? KIND_OTHER : in_kind;
         op_ff   <= (in_alu_op > OP_NONE) ? OP_UNKNOWN : in_alu_op;
         k1_ff   <= (in_first_kind == OPND_BAD) ? OPND_EMPTY : in_first_kind;
         k2_ff   <= (in_second_kind == OPND_BAD) ? OPND_EMPTY : in_second_kind;
         v1_ff   <= in_first_value;
         v2_ff   <= in_second_value;
         s1_ff   <= in_first_symbol;
         s2_ff   <= in_second_symbol;
         dest_ff <= in_dest_symbol;
      end
   end

   tcff_seq_unit #(
      .WIDTH(VALUE_WIDTH)
   ) u_seq_unit (
      .clock (clock),
      .reset (reset),
      .start (cmd.start),
      .is_div(op_ff == OP_DIV),
      .opnd_a(v1_ff),
      .opnd_b(v2_ff),
      .busy  (unit_busy),
      .done  (unit_done),
      .result(unit_res)
   );

   assign lit_pair = (kind_ff == KIND_BINOP) && (k1_ff == OPND_LIT) && (k2_ff == OPND_LIT);

   always_comb begin
      fold_ok   = 1'b1;
      use_unit  = 1'b0;
      quick_val = '0;
      unique case (op_ff)
         OP_ADD: quick_val = v1_ff + v2_ff;
         OP_SUB: quick_val = v1_ff - v2_ff;
         OP_MUL: use_unit = 1'b1;
         OP_DIV: begin
            use_unit = 1'b1;
            fold_ok  = (v2_ff != '0);
         end
         OP_EQ: quick_val = {{(VALUE_WIDTH-1){1'b0}}, v1_ff == v2_ff};
         OP_NE: quick_val = {{(VALUE_WIDTH-1){1'b0}}, v1_ff != v2_ff};
         OP_LT: quick_val = {{(VALUE_WIDTH-1){1'b0}}, v1_ff < v2_ff};
         OP_GT: quick_val = {{(VALUE_WIDTH-1){1'b0}}, v1_ff > v2_ff};
         OP_LE: quick_val = {{(VALUE_WIDTH-1){1'b0}}, v1_ff <= v2_ff};
         OP_GE: quick_val = {{(VALUE_WIDTH-1){1'b0}}, v1_ff >= v2_ff};
         default: fold_ok = 1'b0;
      endcase
   end

   assign fold     = lit_pair && fold_ok;
   assign fold_val = use_unit ? unit_res : quick_val;

   always_comb begin
      f_kind = fold ? KIND_ASSIGN : kind_ff;
      f_k1   = k1_ff;
      f_v1   = fold ? fold_val : v1_ff;
      jz_lit = (kind_ff == KIND_JZ) && (k1_ff == OPND_LIT);
      rkind_in = f_kind;
      rop_in   = fold ? OP_NONE : op_ff;
      rk2_in   = fold ? OPND_EMPTY : k2_ff;
      // jump on literal zero turns into a plain goto
      if (jz_lit) begin
         rkind_in = KIND_GOTO;
         f_k1     = OPND_EMPTY;
      end
      rk1_in = f_k1;
      rv1_in = (f_k1 == OPND_LIT) ? f_v1 : '0;
      rs1_in = (f_k1 == OPND_SYM) ? s1_ff : '0;
      rv2_in = (rk2_in == OPND_LIT) ? v2_ff : '0;
      rs2_in = (rk2_in == OPND_SYM) ? s2_ff : '0;
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rkind_ff <= rkind_in;
         rop_ff   <= rop_in;
         rk1_ff   <= rk1_in;
         rv1_ff   <= rv1_in;
         rs1_ff   <= rs1_in;
         rk2_ff   <= rk2_in;
         rv2_ff   <= rv2_in;
         rs2_ff   <= rs2_in;
         rdest_ff <= dest_ff;
      end
   end

   assign status.is_label    = (kind_ff == KIND_LABEL);
   assign status.needs_unit  = fold && use_unit;
   assign status.emit        = !(jz_lit && (v1_ff != '0));
   assign status.result_goto = (rkind_in == KIND_GOTO);
   assign status.unit_busy   = unit_busy;
   assign status.unit_done   = unit_done;

   assign out_kind          = rkind_ff;
   assign out_alu_op        = rop_ff;
   assign out_first_kind    = rk1_ff;
   assign out_first_value   = rv1_ff;
   assign out_first_symbol  = rs1_ff;
   assign out_second_kind   = rk2_ff;
   assign out_second_value  = rv2_ff;
   assign out_second_symbol = rs2_ff;
   assign out_dest_symbol   = rdest_ff;

endmodule

// ----- rtl/core/tcff_controller.sv -----
`include "assert_macros.svh"

module tcff_controller
   import tcff_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_tvalid,
   output logic            req_tready,
   output logic            rsp_tvalid,
   input  logic            rsp_tready,
   output tcff_cmd_type    cmd,
   input  tcff_status_type status
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_EVAL = 2'd1;
   localparam logic [1:0] ST_CALC = 2'd2;
   localparam logic [1:0] ST_EMIT = 2'd3;

   logic [1:0] state_ff, state_in;
   logic       skip_ff, skip_in;
   logic       out_valid_ff, out_valid_in;
   logic       out_free;

   assign out_free = !out_valid_ff || rsp_tready;

   always_comb begin
      state_in     = state_ff;
      skip_in      = skip_ff;
      cmd.load     = 1'b0;
      cmd.start    = 1'b0;
      cmd.out_load = 1'b0;
      req_tready   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            priority if (skip_ff && !status.is_label) begin
               state_in = ST_IDLE;
            end else if (!status.emit) begin
               skip_in  = 1'b0;
               state_in = ST_IDLE;
            end else if (status.needs_unit) begin
               skip_in   = 1'b0;
               cmd.start = 1'b1;
               state_in  = ST_CALC;
            end else begin
               skip_in  = 1'b0;
               state_in = ST_EMIT;
            end
         end
         ST_CALC: begin
            if (status.unit_done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               skip_in      = status.result_goto;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (cmd.out_load) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         skip_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         skip_ff      <= skip_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;

   `ASSERT_IMPL(a_calc_unit_active, clock, reset, state_ff == ST_CALC,
                status.unit_busy || status.unit_done)
   `ASSERT_NEXT(a_goto_sets_skip, clock, reset, cmd.out_load && status.result_goto, skip_ff)
   `ASSERT_IMPL(a_no_overwrite, clock, reset, cmd.out_load, !out_valid_ff || rsp_tready)

endmodule

// ----- rtl/core/tac_constant_fold_filter_unit.sv -----
// channel   dir  handshake              payload
// req       in   req_tvalid/req_tready  req_tuser instr kind, req_tdata operands
// rsp       out  rsp_tvalid/rsp_tready  rsp_tuser out kind, rsp_tdata operands
//
// an item that passes or folds by add, sub or compare goes through the idle, eval and
// emit states to the result register; the next transfer is taken back in idle
// mul and div run in the bit-serial unit: eval starts it, calc waits for its done flag,
// then emit loads the result register; no new transfer is taken until then
// an item dropped by the skip flag or by a jump on a nonzero literal goes idle, eval, idle
// reset is synchronous and clears the state machine, skip flag and output valid
// the output register holds a result while rsp is stalled; the next item is taken
// meanwhile and its result waits in the emit state until the register frees up
module tac_constant_fold_filter_unit
   import tcff_pkg::*;
#(
   parameter int VALUE_WIDTH  = VALUE_WIDTH_DEF,
   parameter int SYMBOL_WIDTH = SYMBOL_WIDTH_DEF,
   localparam int RAW_W  = OP_W + 2 * OPK_W + 2 * VALUE_WIDTH + 3 * SYMBOL_WIDTH,
   localparam int DATA_W = ((RAW_W + 7) / 8) * 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   // alu_op, first_kind, first_value, first_symbol, second_kind, second_value,
   // second_symbol, dest_symbol, zero fill
   input  logic [DATA_W-1:0] req_tdata,
   // instr_kind
   input  logic [KIND_W-1:0] req_tuser,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   // out_alu_op, out_first_kind, out_first_value, out_first_symbol, out_second_kind,
   // out_second_value, out_second_symbol, out_dest_symbol, zero fill
   output logic [DATA_W-1:0] rsp_tdata,
   // out_kind
   output logic [KIND_W-1:0] rsp_tuser
);

   localparam int OFS_OP = 0;
   localparam int OFS_K1 = OFS_OP + OP_W;
   localparam int OFS_V1 = OFS_K1 + OPK_W;
   localparam int OFS_S1 = OFS_V1 + VALUE_WIDTH;
   localparam int OFS_K2 = OFS_S1 + SYMBOL_WIDTH;
   localparam int OFS_V2 = OFS_K2 + OPK_W;
   localparam int OFS_S2 = OFS_V2 + VALUE_WIDTH;
   localparam int OFS_D  = OFS_S2 + SYMBOL_WIDTH;

   tcff_cmd_type    cmd;
   tcff_status_type status;

   logic [OP_W-1:0]         o_op;
   logic [OPK_W-1:0]        o_k1, o_k2;
   logic [VALUE_WIDTH-1:0]  o_v1, o_v2;
   logic [SYMBOL_WIDTH-1:0] o_s1, o_s2, o_dest;
   logic [RAW_W-1:0]        rsp_raw;

   tcff_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .cmd       (cmd),
      .status    (status)
   );

   tcff_datapath #(
      .VALUE_WIDTH (VALUE_WIDTH),
      .SYMBOL_WIDTH(SYMBOL_WIDTH)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .in_kind          (req_tuser),
      .in_alu_op        (req_tdata[OFS_OP +: OP_W]),
      .in_first_kind    (req_tdata[OFS_K1 +: OPK_W]),
      .in_first_value   (req_tdata[OFS_V1 +: VALUE_WIDTH]),
      .in_first_symbol  (req_tdata[OFS_S1 +: SYMBOL_WIDTH]),
      .in_second_kind   (req_tdata[OFS_K2 +: OPK_W]),
      .in_second_value  (req_tdata[OFS_V2 +: VALUE_WIDTH]),
      .in_second_symbol (req_tdata[OFS_S2 +: SYMBOL_WIDTH]),
      .in_dest_symbol   (req_tdata[OFS_D +: SYMBOL_WIDTH]),
      .out_kind         (rsp_tuser),
      .out_alu_op       (o_op),
      .out_first_kind   (o_k1),
      .out_first_value  (o_v1),
      .out_first_symbol (o_s1),
      .out_second_kind  (o_k2),
      .out_second_value (o_v2),
      .out_second_symbol(o_s2),
      .out_dest_symbol  (o_dest)
   );

   assign rsp_raw   = {o_dest, o_s2, o_v2, o_k2, o_s1, o_v1, o_k1, o_op};
   assign rsp_tdata = DATA_W'(rsp_raw);

endmodule

// ----- test/tac_constant_fold_filter_checker.sv -----
`timescale 1ns / 1ps

module tac_constant_fold_filter_checker
   import tcff_pkg::*;
#(
   parameter int DATA_W = 120
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   input  logic              req_tready,
   // alu_op, first_kind, first_value, first_symbol, second_kind, second_value,
   // second_symbol, dest_symbol
   input  logic [DATA_W-1:0] req_tdata,
   // instr_kind
   input  logic [KIND_W-1:0] req_tuser,
   input  logic              rsp_tvalid,
   input  logic              rsp_tready,
   // out_alu_op, out_first_kind, out_first_value, out_first_symbol, out_second_kind,
   // out_second_value, out_second_symbol, out_dest_symbol
   input  logic [DATA_W-1:0] rsp_tdata,
   // out_kind
   input  logic [KIND_W-1:0] rsp_tuser,
   output int                fail_count,
   output int                pending_count,
   output int                items_taken,
   output int                results_seen,
   output int                folds_seen
);

   // op, the first payload field, in the lowest bits; dest, declared first, in the highest
   typedef struct packed {
      logic [15:0]      dest;
      logic [15:0]      s2;
      logic [31:0]      v2;
      logic [OPK_W-1:0] k2;
      logic [15:0]      s1;
      logic [31:0]      v1;
      logic [OPK_W-1:0] k1;
      logic [OP_W-1:0]  op;
   } tac_operands_type;

   typedef struct {
      logic [KIND_W-1:0] kind;
      tac_operands_type  opnd;
   } tac_instr_type;

   tac_instr_type    emitted_instrs[$];
   tac_instr_type    want;
   tac_instr_type    made;
   tac_operands_type got;
   bit               skip_to_label;
   int               mismatches;
   int               taken;
   int               results;
   int               folds;

   initial begin
      fail_count    = 0;
      pending_count = 0;
      items_taken   = 0;
      results_seen  = 0;
      folds_seen    = 0;
      mismatches    = 0;
      taken         = 0;
      results       = 0;
      folds         = 0;
      skip_to_label = 1'b0;
   end

   task automatic report_mismatch(input string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      mismatches++;
   endtask

   task automatic check_field(input string name, input logic [31:0] seen,
                              input logic [31:0] wanted);
      if (seen !== wanted)
         report_mismatch($sformatf("result %0d field %s got %0h expected %0h",
                                   results, name, seen, wanted));
   endtask

   function automatic bit fold_literals(input logic [OP_W-1:0] op,
                                        input logic signed [31:0] a,
                                        input logic signed [31:0] b,
                                        output logic [31:0] r);
      r = '0;
      case (op)
         OP_ADD: r = a + b;
         OP_SUB: r = a - b;
         OP_MUL: r = a * b;
         OP_DIV: begin
            if (b == 0) return 1'b0;
            // most negative over minus one wraps onto itself
            if (a == 32'sh8000_0000 && b == -1) r = a;
            else r = a / b;
         end
         OP_EQ: r = {31'd0, a == b};
         OP_NE: r = {31'd0, a != b};
         OP_LT: r = {31'd0, a < b};
         OP_GT: r = {31'd0, a > b};
         OP_LE: r = {31'd0, a <= b};
         OP_GE: r = {31'd0, a >= b};
         default: return 1'b0;
      endcase
      return 1'b1;
   endfunction

   function automatic bit fold_and_filter(input logic [KIND_W-1:0] kind_in,
                                          input tac_operands_type f,
                                          output tac_instr_type res);
      logic [KIND_W-1:0] kind;
      logic [OP_W-1:0]   op;
      logic [OPK_W-1:0]  k1;
      logic [OPK_W-1:0]  k2;
      logic [31:0]       v1;
      logic [31:0]       folded;
      kind = (kind_in > KIND_OTHER) ? KIND_OTHER : kind_in;
      op   = (f.op > OP_NONE) ? OP_UNKNOWN : f.op;
      k1   = (f.k1 == OPND_BAD) ? OPND_EMPTY : f.k1;
      k2   = (f.k2 == OPND_BAD) ? OPND_EMPTY : f.k2;
      v1   = f.v1;
      res.kind = '0;
      res.opnd = '0;
      if (skip_to_label) begin
         if (kind != KIND_LABEL) return 1'b0;
         skip_to_label = 1'b0;
      end
      if (kind == KIND_BINOP && k1 == OPND_LIT && k2 == OPND_LIT &&
          fold_literals(op, f.v1, f.v2, folded)) begin
         kind = KIND_ASSIGN;
         op   = OP_NONE;
         v1   = folded;
         k2   = OPND_EMPTY;
         folds++;
      end
      // jump on a literal: taken becomes goto, never taken vanishes
      if (kind == KIND_JZ && k1 == OPND_LIT) begin
         if (v1 != 0) return 1'b0;
         kind = KIND_GOTO;
         k1   = OPND_EMPTY;
      end
      res.kind    = kind;
      res.opnd.op = op;
      res.opnd.k1 = k1;
      res.opnd.v1 = (k1 == OPND_LIT) ? v1 : '0;
      res.opnd.s1 = (k1 == OPND_SYM) ? f.s1 : '0;
      res.opnd.k2 = k2;
      res.opnd.v2 = (k2 == OPND_LIT) ? f.v2 : '0;
      res.opnd.s2 = (k2 == OPND_SYM) ? f.s2 : '0;
      res.opnd.dest = f.dest;
      if (kind == KIND_GOTO) skip_to_label = 1'b1;
      return 1'b1;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         skip_to_label = 1'b0;
         emitted_instrs.delete();
      end else begin
         // result side first: a result never belongs to a same-edge request
         if (rsp_tvalid && rsp_tready) begin
            if (emitted_instrs.size() == 0) begin
               report_mismatch($sformatf("result with nothing expected, kind %0d data %0h",
                                         rsp_tuser, rsp_tdata));
            end else begin
               want = emitted_instrs.pop_front();
               got  = rsp_tdata;
               check_field("out_kind", 32'(rsp_tuser), 32'(want.kind));
               check_field("out_alu_op", 32'(got.op), 32'(want.opnd.op));
               check_field("out_first_kind", 32'(got.k1), 32'(want.opnd.k1));
               check_field("out_first_value", got.v1, want.opnd.v1);
               check_field("out_first_symbol", 32'(got.s1), 32'(want.opnd.s1));
               check_field("out_second_kind", 32'(got.k2), 32'(want.opnd.k2));
               check_field("out_second_value", got.v2, want.opnd.v2);
               check_field("out_second_symbol", 32'(got.s2), 32'(want.opnd.s2));
               check_field("out_dest_symbol", 32'(got.dest), 32'(want.opnd.dest));
            end
            results++;
         end
         if (req_tvalid && req_tready) begin
            if (!skip_to_label || req_tuser == KIND_LABEL) taken++;
            if (fold_and_filter(req_tuser, req_tdata, made))
               emitted_instrs.push_back(made);
         end
      end
      fail_count    <= mismatches;
      pending_count <= emitted_instrs.size();
      items_taken   <= taken;
      results_seen  <= results;
      folds_seen    <= folds;
   end

endmodule

// ----- test/tb_tac_constant_fold_filter_unit.sv -----
`timescale 1ns / 1ps

module tb_tac_constant_fold_filter_unit;
   import tcff_pkg::*;

   localparam int RAW_W  = OP_W + 2 * OPK_W + 2 * VALUE_WIDTH_DEF + 3 * SYMBOL_WIDTH_DEF;
   localparam int DATA_W = ((RAW_W + 7) / 8) * 8;

   localparam int ITEMS        = 1950;
   localparam int LIMIT_CYCLES = 600000;
   localparam int TAIL_CYCLES  = 64;

   localparam logic [31:0] MAXV = 32'h7fff_ffff;
   localparam logic [31:0] MINV = 32'h8000_0000;
   localparam logic [31:0] NEG1 = 32'hffff_ffff;

   logic              clock;
   logic              reset;
   logic              req_tvalid;
   logic              req_tready;
   logic [DATA_W-1:0] req_tdata;
   logic [KIND_W-1:0] req_tuser;
   logic              rsp_tvalid;
   logic              rsp_tready;
   logic [DATA_W-1:0] rsp_tdata;
   logic [KIND_W-1:0] rsp_tuser;

   int fail_count;
   int pending_count;
   int items_taken;
   int results_seen;
   int folds_seen;

   int sent_count;
   int cycles;
   int stall_left;
   bit calm;
   bit paused;

   tac_constant_fold_filter_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   tac_constant_fold_filter_checker #(.DATA_W(DATA_W)) u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .fail_count    (fail_count),
      .pending_count (pending_count),
      .items_taken   (items_taken),
      .results_seen  (results_seen),
      .folds_seen    (folds_seen)
   );

   initial begin
      clock      = 1'b0;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = '0;
      rsp_tready = 1'b0;
      stall_left = 0;
      cycles     = 0;
      calm       = 1'b0;
   end

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= LIMIT_CYCLES) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycles, pending_count);
         $display("TEST FAILED");
         $finish;
      end
   end

   // result side back-pressure in bursts
   always @(posedge clock) begin
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 99) < 12) begin
         stall_left <= $urandom_range(0, 10);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   task automatic send_instr(input logic [KIND_W-1:0] kind, input logic [OP_W-1:0] op,
                             input logic [OPK_W-1:0] k1, input logic [31:0] v1,
                             input logic [15:0] s1, input logic [OPK_W-1:0] k2,
                             input logic [31:0] v2, input logic [15:0] s2,
                             input logic [15:0] dest);
      req_tuser  <= kind;
      req_tdata  <= {dest, s2, v2, k2, s1, v1, k1, op};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sent_count++;
      if (!calm && $urandom_range(0, 99) < 25) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
   endtask

   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 9))
         0: return MAXV;
         1: return MINV;
         2: return '0;
         3: return NEG1;
         4: return 32'd1;
         5, 6: return $urandom_range(0, 32) - 16;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [OPK_W-1:0] pick_opnd_kind(input bit lit_bias);
      if (lit_bias && $urandom_range(0, 99) < 80) return OPND_LIT;
      return OPK_W'($urandom_range(0, 3));
   endfunction

   task automatic send_random_instr();
      logic [KIND_W-1:0] kind;
      logic [OP_W-1:0]   op;
      int                r;
      r = $urandom_range(0, 99);
      if (r < 35)      kind = KIND_BINOP;
      else if (r < 50) kind = KIND_JZ;
      else if (r < 58) kind = KIND_GOTO;
      else if (r < 75) kind = KIND_LABEL;
      else if (r < 85) kind = KIND_ASSIGN;
      else if (r < 93) kind = KIND_OTHER;
      else             kind = KIND_W'($urandom_range(6, 7));
      if ($urandom_range(0, 99) < 85) op = OP_W'($urandom_range(OP_ADD, OP_GE));
      else op = OP_W'($urandom_range(OP_UNKNOWN, 15));
      send_instr(kind, op,
                 pick_opnd_kind(kind == KIND_BINOP || kind == KIND_JZ), pick_value(),
                 16'($urandom),
                 pick_opnd_kind(kind == KIND_BINOP), pick_value(), 16'($urandom),
                 16'($urandom));
   endtask

   initial begin
      sent_count = 0;
      paused     = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: wrap-around, every operator, no-fold cases, odd encodings
      send_instr(KIND_LABEL, OP_NONE, OPND_EMPTY, '0, '0, OPND_EMPTY, '0, '0, 16'hffff);
      send_instr(KIND_BINOP, OP_ADD, OPND_LIT, MAXV, '0, OPND_LIT, 32'd1, '0, 16'h0001);
      send_instr(KIND_BINOP, OP_SUB, OPND_LIT, MINV, '0, OPND_LIT, 32'd1, '0, 16'h0002);
      send_instr(KIND_BINOP, OP_MUL, OPND_LIT, MAXV, '0, OPND_LIT, MAXV, '0, 16'h0003);
      send_instr(KIND_BINOP, OP_DIV, OPND_LIT, MINV, '0, OPND_LIT, NEG1, '0, 16'h0004);
      send_instr(KIND_BINOP, OP_DIV, OPND_LIT, 32'd7, '0, OPND_LIT, '0, '0, 16'h0005);
      send_instr(KIND_BINOP, OP_DIV, OPND_LIT, -32'sd7, '0, OPND_LIT, 32'd2, '0, 16'h0006);
      send_instr(KIND_BINOP, OP_EQ, OPND_LIT, 32'd5, '0, OPND_LIT, 32'd5, '0, 16'h0007);
      send_instr(KIND_BINOP, OP_NE, OPND_LIT, 32'd5, '0, OPND_LIT, 32'd5, '0, 16'h0008);
      send_instr(KIND_BINOP, OP_LT, OPND_LIT, NEG1, '0, OPND_LIT, '0, '0, 16'h0009);
      send_instr(KIND_BINOP, OP_GT, OPND_LIT, MINV, '0, OPND_LIT, MAXV, '0, 16'h000a);
      send_instr(KIND_BINOP, OP_LE, OPND_LIT, 32'd3, '0, OPND_LIT, 32'd3, '0, 16'h000b);
      send_instr(KIND_BINOP, OP_GE, OPND_LIT, NEG1, '0, OPND_LIT, 32'd1, '0, 16'h000c);
      send_instr(KIND_BINOP, OP_UNKNOWN, OPND_LIT, 32'd1, '0, OPND_LIT, 32'd2, '0, 16'h000d);
      send_instr(KIND_BINOP, 4'd15, OPND_LIT, 32'd1, '0, OPND_LIT, 32'd2, '0, 16'h000e);
      send_instr(KIND_BINOP, OP_NONE, OPND_LIT, 32'd1, '0, OPND_LIT, 32'd2, '0, 16'h000f);
      send_instr(KIND_BINOP, OP_ADD, OPND_LIT, 32'd4, 16'hffff, OPND_SYM, NEG1, 16'hffff,
                 16'h0010);
      // bad operand kinds carry garbage that must come out as zero
      send_instr(KIND_ASSIGN, OP_NONE, OPND_BAD, NEG1, 16'hffff, OPND_BAD, NEG1, 16'hffff,
                 16'h0011);
      send_instr(3'd6, OP_NONE, OPND_SYM, NEG1, 16'h1234, OPND_EMPTY, NEG1, 16'hffff,
                 16'h0012);
      send_instr(3'd7, OP_ADD, OPND_LIT, MAXV, 16'hffff, OPND_LIT, MINV, 16'hffff, 16'h0013);
      send_instr(KIND_JZ, OP_NONE, OPND_LIT, MINV, '0, OPND_EMPTY, '0, '0, 16'h0014);
      send_instr(KIND_JZ, OP_NONE, OPND_SYM, '0, 16'h00aa, OPND_EMPTY, '0, '0, 16'h0015);
      send_instr(KIND_JZ, OP_NONE, OPND_LIT, '0, '0, OPND_EMPTY, '0, '0, 16'h0016);
      // now skipping: these two vanish, the label restarts emission
      send_instr(KIND_BINOP, OP_ADD, OPND_LIT, 32'd1, '0, OPND_LIT, 32'd1, '0, 16'h0017);
      send_instr(KIND_GOTO, OP_NONE, OPND_EMPTY, '0, '0, OPND_EMPTY, '0, '0, 16'h0018);
      send_instr(KIND_LABEL, OP_NONE, OPND_EMPTY, '0, '0, OPND_EMPTY, '0, '0, 16'h0019);
      send_instr(KIND_GOTO, OP_NONE, OPND_EMPTY, '0, '0, OPND_EMPTY, '0, '0, 16'h001a);
      send_instr(KIND_LABEL, OP_NONE, OPND_EMPTY, '0, '0, OPND_EMPTY, '0, '0, 16'h0000);

      while (sent_count < ITEMS) begin
         if (!paused && sent_count >= ITEMS / 2) begin
            // drain the block completely once, mid-run
            paused = 1'b1;
            req_tvalid <= 1'b0;
            @(posedge clock);
            while (pending_count != 0) @(posedge clock);
         end
         if (!calm && sent_count >= ITEMS - ITEMS / 10) calm <= 1'b1;
         send_random_instr();
      end
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("covered %0d instructions sent, %0d past the skip flag, %0d results checked",
               sent_count, items_taken, results_seen);
      $display("%0d binary operations folded, one full drain mid-run, %0d mismatches",
               folds_seen, fail_count);
      if (fail_count == 0 && pending_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
